// ===== hw/rtl/tacd_pkg.sv =====
`default_nettype none
package tacd_pkg;

    // stream and field widths
    localparam int unsigned COORD_W   = 32;
    localparam int unsigned N_COORD   = 9;
    localparam int unsigned S_TDATA_W = 288;
    localparam int unsigned AREA_W    = 63;
    localparam int unsigned DIAM_W    = 48;
    localparam int unsigned M_TDATA_W = 112;

    // embedding dimension codes
    localparam logic [1:0] EMBED_3D    = 2'd3;
    localparam logic [1:0] EMBED_RESET = 2'd2;

    // per-item flags carried down the divide and root stages
    typedef struct packed {
        logic degenerate;
        logic area_sat;
        logic diam_max;
    } flags_t;

    // one finished result, area in the low bits
    typedef struct packed {
        logic              degenerate;
        logic [DIAM_W-1:0] diameter;
        logic [AREA_W-1:0] area;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/triangle_area_and_circumdiameter.sv =====
`default_nettype none
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: ax ay az bx by_coord bz cx cy cz (32 b each)
// m_        out  m_tvalid/m_tready  m_tdata: area (63 b) diameter (48 b); m_tuser: degenerate
// cfg_      in   cfg_wr_en          cfg_wr_data: embed_dim (2 b)
//
// one triangle per cycle while s_tready is high (output buffer not full)
// depth is set by the 96-step quotient and the 48-step root, one bit per register stage
// a two-entry output buffer takes finished results; the pipeline freezes only when it is full
// aresetn clears valid bits, buffer count and embed_dim (to 2-D); data registers are not reset
module triangle_area_and_circumdiameter (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [1:0]                       cfg_wr_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz
    input  wire logic [tacd_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // area, diameter, zero pad
    output logic [tacd_pkg::M_TDATA_W-1:0]        m_tdata,
    // degenerate
    output logic [0:0]                            m_tuser
);

    logic [1:0] embed_dim_reg;
    logic       adv;
    logic [1:0] obuf_cnt_reg, obuf_cnt_next;
    logic       push, pop;
    tacd_pkg::result_t res, head_reg, tail_reg;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            embed_dim_reg <= tacd_pkg::EMBED_RESET;
        end else if (cfg_wr_en) begin
            embed_dim_reg <= cfg_wr_data;
        end
    end

    assign adv      = (obuf_cnt_reg != 2'd2);
    assign s_tready = adv;

    // stage valid bits for the front end
    logic [7:0] fe_vld_reg;

    // s1: vertex differences u = B-A, v = C-A, w = B-C
    logic signed [31:0] crd [9];
    logic signed [32:0] d_next [9];
    logic signed [32:0] d_reg [9];

    always_comb begin
        for (int i = 0; i < tacd_pkg::N_COORD; i++) begin
            crd[i] = s_tdata[tacd_pkg::COORD_W*i +: tacd_pkg::COORD_W];
        end
        if (embed_dim_reg != tacd_pkg::EMBED_3D) begin
            crd[2] = '0;
            crd[5] = '0;
            crd[8] = '0;
        end
        d_next[0] = 33'(crd[3]) - 33'(crd[0]);
        d_next[1] = 33'(crd[4]) - 33'(crd[1]);
        d_next[2] = 33'(crd[5]) - 33'(crd[2]);
        d_next[3] = 33'(crd[6]) - 33'(crd[0]);
        d_next[4] = 33'(crd[7]) - 33'(crd[1]);
        d_next[5] = 33'(crd[8]) - 33'(crd[2]);
        d_next[6] = 33'(crd[3]) - 33'(crd[6]);
        d_next[7] = 33'(crd[4]) - 33'(crd[7]);
        d_next[8] = 33'(crd[5]) - 33'(crd[8]);
    end

    // s2: cross product terms and squared differences
    logic signed [65:0] cp_next [6];
    logic signed [65:0] cp_reg [6];
    logic signed [65:0] sq_full [9];
    logic [64:0]        sqd_next [9];
    logic [64:0]        sqd_reg [9];

    always_comb begin
        cp_next[0] = d_reg[1] * d_reg[5];
        cp_next[1] = d_reg[2] * d_reg[4];
        cp_next[2] = d_reg[2] * d_reg[3];
        cp_next[3] = d_reg[0] * d_reg[5];
        cp_next[4] = d_reg[0] * d_reg[4];
        cp_next[5] = d_reg[1] * d_reg[3];
        for (int i = 0; i < 9; i++) begin
            sq_full[i]  = d_reg[i] * d_reg[i];
            sqd_next[i] = sq_full[i][64:0];
        end
    end

    // s3: absolute cross product components and squared side lengths
    logic signed [66:0] cdif [3];
    logic [65:0]        cm_next [3];
    logic [65:0]        cm_reg [3];
    logic [65:0]        len_next [3];
    logic [65:0]        len_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cdif[i]     = 67'(cp_reg[2*i]) - 67'(cp_reg[2*i+1]);
            cm_next[i]  = cdif[i][66] ? 66'(-cdif[i]) : 66'(cdif[i]);
            len_next[i] = 66'(sqd_reg[3*i]) + 66'(sqd_reg[3*i+1]) + 66'(sqd_reg[3*i+2]);
        end
    end

    // s4: partial products of 33-bit halves for the squares and for la*lb
    logic [65:0] xp_next [3][3];
    logic [65:0] xp_reg [3][3];
    logic [65:0] lp_next [4];
    logic [65:0] lp_reg [4];
    logic [65:0] lc4_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            xp_next[i][0] = cm_reg[i][65:33] * cm_reg[i][65:33];
            xp_next[i][1] = cm_reg[i][65:33] * cm_reg[i][32:0];
            xp_next[i][2] = cm_reg[i][32:0] * cm_reg[i][32:0];
        end
        lp_next[0] = len_reg[2][65:33] * len_reg[1][65:33];
        lp_next[1] = len_reg[2][65:33] * len_reg[1][32:0];
        lp_next[2] = len_reg[2][32:0] * len_reg[1][65:33];
        lp_next[3] = len_reg[2][32:0] * len_reg[1][32:0];
    end

    // s5: assemble the three squares and la*lb
    logic [131:0] sqr_next [3];
    logic [131:0] sqr_reg [3];
    logic [131:0] lab_next, lab_reg;
    logic [65:0]  lc5_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sqr_next[i] = {xp_reg[i][0], 66'b0} + 132'({xp_reg[i][1], 34'b0})
                        + 132'(xp_reg[i][2]);
        end
        lab_next = {lp_reg[0], 66'b0} + 132'({lp_reg[1], 33'b0})
                 + 132'({lp_reg[2], 33'b0}) + 132'(lp_reg[3]);
    end

    // s6: squared cross length, partial products of la*lb*lc
    logic [131:0] x2s6_next, x2s6_reg;
    logic [65:0]  np_next [2][4];
    logic [65:0]  np_reg [2][4];

    always_comb begin
        x2s6_next = sqr_reg[0] + sqr_reg[1] + sqr_reg[2];
        for (int h = 0; h < 2; h++) begin
            for (int i = 0; i < 4; i++) begin
                np_next[h][i] = lab_reg[33*i +: 33] * lc5_reg[33*h +: 33];
            end
        end
    end

    // s7: row sums of the numerator
    logic [131:0] x2s7_reg;
    logic [197:0] nh_next [2];
    logic [197:0] nh_reg [2];

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            nh_next[h] = '0;
            for (int i = 0; i < 4; i++) begin
                nh_next[h] = nh_next[h] + (198'(np_reg[h][i]) << (33*i));
            end
        end
    end

    // s8: numerator a^2 b^2 c^2
    logic [131:0] x2s8_reg;
    logic [197:0] n_next, n_reg;

    assign n_next = nh_reg[0] + (nh_reg[1] << 33);

    // front end registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg    <= d_next;
            cp_reg   <= cp_next;
            sqd_reg  <= sqd_next;
            cm_reg   <= cm_next;
            len_reg  <= len_next;
            xp_reg   <= xp_next;
            lp_reg   <= lp_next;
            lc4_reg  <= len_reg[0];
            sqr_reg  <= sqr_next;
            lab_reg  <= lab_next;
            lc5_reg  <= lc4_reg;
            x2s6_reg <= x2s6_next;
            np_reg   <= np_next;
            x2s7_reg <= x2s6_reg;
            nh_reg   <= nh_next;
            x2s8_reg <= x2s7_reg;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fe_vld_reg <= '0;
        end else if (adv) begin
            fe_vld_reg <= {fe_vld_reg[6:0], s_tvalid};
        end
    end

    // divide stages: quotient n / x2 and, alongside, the area root
    logic [197:0]            dv_rem_reg  [0:96];
    logic [95:0]             dv_quo_reg  [0:96];
    logic [131:0]            dv_x2_reg   [0:96];
    logic [125:0]            ar_rem_reg  [0:96];
    logic [62:0]             ar_root_reg [0:96];
    tacd_pkg::flags_t        dv_flag_reg [0:96];
    logic                    dv_vld_reg  [0:96];
    tacd_pkg::flags_t        s9_flags;

    // s9: flags and start values
    always_comb begin
        s9_flags.degenerate = (x2s8_reg[131:2] == '0);
        s9_flags.area_sat   = (x2s8_reg[131:128] != '0);
        s9_flags.diam_max   = s9_flags.degenerate || (132'(n_reg[197:96]) >= x2s8_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_rem_reg[0]  <= n_reg;
            dv_quo_reg[0]  <= '0;
            dv_x2_reg[0]   <= x2s8_reg;
            ar_rem_reg[0]  <= x2s8_reg[127:2];
            ar_root_reg[0] <= '0;
            dv_flag_reg[0] <= s9_flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_vld_reg[0] <= fe_vld_reg[7];
        end
    end

    for (genvar j = 0; j < 96; j++) begin : g_div
        localparam int unsigned K = 95 - j;
        logic [227:0] div_trial;
        logic         div_fit;

        // one quotient bit per stage
        assign div_trial = 228'(dv_x2_reg[j]) << K;
        assign div_fit   = (228'(dv_rem_reg[j]) >= div_trial);

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_rem_reg[j+1]    <= div_fit ? dv_rem_reg[j] - div_trial[197:0] : dv_rem_reg[j];
                dv_quo_reg[j+1]    <= dv_quo_reg[j] | (96'(div_fit) << K);
                dv_x2_reg[j+1]     <= dv_x2_reg[j];
                dv_flag_reg[j+1]   <= dv_flag_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[j+1] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end

        if (j < 63) begin : g_aroot
            localparam int unsigned B = 62 - j;
            logic [126:0] ar_trial;
            logic         ar_fit;

            // one area root bit per stage
            assign ar_trial = (127'(ar_root_reg[j]) << (B + 1)) + (127'(1) << (2 * B));
            assign ar_fit   = (127'(ar_rem_reg[j]) >= ar_trial);

            always_ff @(posedge aclk) begin
                if (adv) begin
                    ar_rem_reg[j+1]     <= ar_fit ? ar_rem_reg[j] - ar_trial[125:0]
                                                  : ar_rem_reg[j];
                    ar_root_reg[j+1]    <= ar_root_reg[j] | (63'(ar_fit) << B);
                end
            end
        end else begin : g_apass
            always_ff @(posedge aclk) begin
                if (adv) begin
                    ar_rem_reg[j+1]  <= ar_rem_reg[j];
                    ar_root_reg[j+1] <= ar_root_reg[j];
                end
            end
        end
    end

    // root stages: diameter = isqrt(quotient)
    logic [95:0]      sq_rem_reg  [0:47];
    logic [47:0]      sq_root_reg [0:47];
    logic [62:0]      sq_area_reg [0:47];
    tacd_pkg::flags_t sq_flag_reg [0:47];
    logic             sq_vld_reg  [0:47];

    for (genvar j = 0; j < 48; j++) begin : g_droot
        localparam int unsigned B = 47 - j;
        logic [95:0]      rem_in;
        logic [47:0]      root_in;
        logic [62:0]      area_in;
        tacd_pkg::flags_t flg_in;
        logic             vld_in;
        logic [96:0]      dr_trial;
        logic             dr_fit;

        if (j == 0) begin : g_head
            assign rem_in  = dv_quo_reg[96];
            assign root_in = '0;
            assign area_in = ar_root_reg[96];
            assign flg_in  = dv_flag_reg[96];
            assign vld_in  = dv_vld_reg[96];
        end else begin : g_body
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
            assign area_in = sq_area_reg[j-1];
            assign flg_in  = sq_flag_reg[j-1];
            assign vld_in  = sq_vld_reg[j-1];
        end

        // one diameter bit per stage
        assign dr_trial = (97'(root_in) << (B + 1)) + (97'(1) << (2 * B));
        assign dr_fit   = (97'(rem_in) >= dr_trial);

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_rem_reg[j]     <= dr_fit ? rem_in - dr_trial[95:0] : rem_in;
                sq_root_reg[j]    <= root_in | (48'(dr_fit) << B);
                sq_area_reg[j]    <= area_in;
                sq_flag_reg[j]    <= flg_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[j] <= 1'b0;
            end else if (adv) begin
                sq_vld_reg[j] <= vld_in;
            end
        end
    end

    // saturation and result
    always_comb begin
        res.degenerate = sq_flag_reg[47].degenerate;
        res.area       = sq_flag_reg[47].area_sat ? '1 : sq_area_reg[47];
        res.diameter   = sq_flag_reg[47].diam_max ? '1 : sq_root_reg[47];
    end

    // two-entry output buffer
    assign push = adv && sq_vld_reg[47];
    assign pop  = (obuf_cnt_reg != 2'd0) && m_tready;

    always_comb begin
        obuf_cnt_next = obuf_cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obuf_cnt_reg <= 2'd0;
        end else begin
            obuf_cnt_reg <= obuf_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (obuf_cnt_reg == 2'd2) begin
                head_reg <= tail_reg;
            end else if (push) begin
                head_reg <= res;
            end
        end else if (push) begin
            if (obuf_cnt_reg == 2'd0) begin
                head_reg <= res;
            end else begin
                tail_reg <= res;
            end
        end
    end

    assign m_tvalid = (obuf_cnt_reg != 2'd0);
    assign m_tdata  = {1'b0, head_reg.diameter, head_reg.area};
    assign m_tuser  = head_reg.degenerate;

    // buffer never overfills
    a_obuf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        obuf_cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    // a degenerate result carries zero area and the largest diameter
    a_degen_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[62:0] == '0) && (m_tdata[110:63] == '1))
        else $error("degenerate result with bad area or diameter");

    // in 2-D the z differences enter as zero
    a_flat_z: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (embed_dim_reg != tacd_pkg::EMBED_3D)
        |=> (d_reg[2] == '0) && (d_reg[5] == '0) && (d_reg[8] == '0))
        else $error("z difference not zero in 2-D");

    // a full buffer holds the pipeline
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (obuf_cnt_reg == 2'd2) && sq_vld_reg[47] |=> sq_vld_reg[47])
        else $error("result lost while output buffer full");

endmodule
`default_nettype wire
